### rtl/core/rld_pkg.sv
// shared types, codes and constants of the run-length digit decoder
`default_nettype none

package rld_pkg;

  // output limit per stream and the counter width that can hold it
  localparam int unsigned MaxOut = 1024;
  localparam int unsigned CntW   = $clog2(MaxOut + 1);

  // digit range of the encoded stream
  localparam logic [7:0] DigitLo = 8'h30;
  localparam logic [7:0] DigitHi = 8'h39;

  // width of the run counter (single digit counts)
  localparam int unsigned RunW = 4;

  // stream condition codes
  localparam logic [1:0] CondRunning = 2'd0;
  localparam logic [1:0] CondLeading = 2'd1;
  localparam logic [1:0] CondTrunc   = 2'd2;

  // result status codes
  localparam logic [2:0] StatData    = 3'd0;
  localparam logic [2:0] StatOk      = 3'd1;
  localparam logic [2:0] StatEmpty   = 3'd2;
  localparam logic [2:0] StatLeading = 3'd3;
  localparam logic [2:0] StatTrunc   = 3'd4;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_flag;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       run_last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic take_item;
    logic emit_step;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic run_start;
    logic last_step;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/rld_ctrl.sv
// controller state machine: item intake and run sequencing
`default_nettype none

module rld_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rld_pkg::dp_status_t stat_i,
  output rld_pkg::ctrl_cmd_t      cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;

  // next state and commands
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.take_item = 1'b0;
    cmd_o.emit_step = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o      = stat_i.slot_free;
        cmd_o.take_item = in_valid_i & stat_i.slot_free;
        if (cmd_o.take_item && stat_i.run_start) begin
          state_d = StRun;
        end
      end
      StRun: begin
        cmd_o.emit_step = stat_i.slot_free;
        if (cmd_o.emit_step && stat_i.last_step) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rld_dp.sv
// datapath: stream state, run counter and output register
`default_nettype none

module rld_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rld_pkg::in_item_t  in_item_i,
  input  wire rld_pkg::ctrl_cmd_t cmd_i,
  output rld_pkg::dp_status_t     stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rld_pkg::out_item_t      out_item_o
);

  logic [7:0]              prev_q;
  logic [7:0]              cur_q;
  logic                    seen_q;
  logic [rld_pkg::CntW-1:0] count_q;
  logic [1:0]              cond_q;
  logic [rld_pkg::RunW-1:0] run_q;
  logic                    out_valid_q;
  rld_pkg::out_item_t      out_q;

  logic                    is_digit;
  logic [7:0]              digit_val;
  logic                    limit_hit;
  logic [2:0]              end_status;

  // input decode
  assign is_digit  = (in_item_i.char_byte >= rld_pkg::DigitLo) &&
                     (in_item_i.char_byte <= rld_pkg::DigitHi);
  assign digit_val = in_item_i.char_byte - rld_pkg::DigitLo;
  assign limit_hit = (count_q == rld_pkg::CntW'(rld_pkg::MaxOut - 1));

  // status toward the controller
  assign stat_o.slot_free = ~out_valid_q | out_ready_i;
  assign stat_o.run_start = ~in_item_i.end_flag & seen_q & is_digit &
                            (cond_q == rld_pkg::CondRunning) & (digit_val != 8'd0);
  assign stat_o.last_step = (run_q == rld_pkg::RunW'(1)) | limit_hit;

  // end-of-stream status
  always_comb begin
    if (!seen_q) begin
      end_status = rld_pkg::StatEmpty;
    end else if (cond_q == rld_pkg::CondLeading) begin
      end_status = rld_pkg::StatLeading;
    end else if (cond_q == rld_pkg::CondTrunc) begin
      end_status = rld_pkg::StatTrunc;
    end else begin
      end_status = rld_pkg::StatOk;
    end
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      seen_q  <= 1'b0;
      count_q <= '0;
      cond_q  <= rld_pkg::CondRunning;
      run_q   <= '0;
    end else if (cmd_i.take_item) begin
      if (in_item_i.end_flag) begin
        prev_q  <= '0;
        seen_q  <= 1'b0;
        count_q <= '0;
        cond_q  <= rld_pkg::CondRunning;
      end else if (!seen_q) begin
        seen_q <= 1'b1;
        prev_q <= in_item_i.char_byte;
        if (is_digit) begin
          cond_q <= rld_pkg::CondLeading;
        end
      end else if (stat_o.run_start) begin
        run_q <= digit_val[rld_pkg::RunW-1:0];
      end else begin
        prev_q <= in_item_i.char_byte;
      end
    end else if (cmd_i.emit_step) begin
      count_q <= count_q + rld_pkg::CntW'(1);
      run_q   <= run_q - rld_pkg::RunW'(1);
      if (stat_o.last_step) begin
        prev_q <= cur_q;
        if (limit_hit) begin
          cond_q <= rld_pkg::CondTrunc;
        end
      end
    end
  end

  // digit byte held for the end of its run
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      cur_q <= in_item_i.char_byte;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.take_item && in_item_i.end_flag) || cmd_i.emit_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && in_item_i.end_flag) begin
      out_q.out_byte <= '0;
      out_q.status   <= end_status;
      out_q.run_last <= 1'b1;
    end else if (cmd_i.emit_step) begin
      out_q.out_byte <= prev_q;
      out_q.status   <= rld_pkg::StatData;
      out_q.run_last <= stat_o.last_step;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/run_length_digit_decoder_top.sv
// top level of the run-length digit decoder
// an end item's result is registered at the clock edge that transfers it
// items are taken only while the single output register is free; the bytes of
// a digit run (up to 9) step through it, and intake is held until the run ends
// a new item is taken while the previous result waits if that result leaves
// reset: asynchronous active low, stream state returns to empty with no error
`default_nettype none

module run_length_digit_decoder_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rld_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rld_pkg::out_item_t      out_item_o
);

  rld_pkg::ctrl_cmd_t  cmd;
  rld_pkg::dp_status_t stat;

  // controller
  rld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  rld_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### tb/run_length_digit_decoder_checker.sv
// scoreboard that predicts and checks the decoded byte stream of the decoder
module run_length_digit_decoder_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  rld_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  rld_pkg::out_item_t out_item_i,
  output int unsigned        mismatches_o,
  output int unsigned        backlog_o,
  output int unsigned        results_seen_o,
  output int unsigned        ends_ok_o,
  output int unsigned        ends_empty_o,
  output int unsigned        ends_leading_o,
  output int unsigned        ends_trunc_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted stream state
  logic [7:0]       last_byte;
  logic             stream_open;
  int unsigned      bytes_emitted;
  logic [1:0]       stream_cond;

  // decoded results still owed by the block, oldest first
  rld_pkg::out_item_t owed_results[$];

  function automatic bit is_digit(input logic [7:0] b);
    return (b >= rld_pkg::DigitLo) && (b <= rld_pkg::DigitHi);
  endfunction

  task automatic clear_stream();
    last_byte     = '0;
    stream_open   = 1'b0;
    bytes_emitted = 0;
    stream_cond   = rld_pkg::CondRunning;
  endtask

  // work out the results one accepted item causes and queue them
  task automatic decode_item(input rld_pkg::in_item_t item);
    rld_pkg::out_item_t res;
    logic [2:0]  ending;
    int unsigned run_len;
    int unsigned made;
    if (item.end_flag) begin
      if (!stream_open) begin
        ending = rld_pkg::StatEmpty;
        ends_empty_o++;
      end else if (stream_cond == rld_pkg::CondLeading) begin
        ending = rld_pkg::StatLeading;
        ends_leading_o++;
      end else if (stream_cond == rld_pkg::CondTrunc) begin
        ending = rld_pkg::StatTrunc;
        ends_trunc_o++;
      end else begin
        ending = rld_pkg::StatOk;
        ends_ok_o++;
      end
      res.out_byte = '0;
      res.status   = ending;
      res.run_last = 1'b1;
      owed_results.push_back(res);
      clear_stream();
    end else if (!stream_open) begin
      // first byte of a stream only primes it; a digit here spoils the stream
      stream_open = 1'b1;
      last_byte   = item.char_byte;
      if (is_digit(item.char_byte)) begin
        stream_cond = rld_pkg::CondLeading;
      end
    end else begin
      if (stream_cond == rld_pkg::CondRunning && is_digit(item.char_byte)) begin
        run_len = item.char_byte - rld_pkg::DigitLo;
        made    = 0;
        // repeat the previous byte, stopping early at the output limit
        while (made < run_len && stream_cond == rld_pkg::CondRunning) begin
          made++;
          bytes_emitted++;
          if (bytes_emitted >= rld_pkg::MaxOut) begin
            stream_cond = rld_pkg::CondTrunc;
          end
          res.out_byte = last_byte;
          res.status   = rld_pkg::StatData;
          res.run_last = (made == run_len) || (stream_cond == rld_pkg::CondTrunc);
          owed_results.push_back(res);
        end
      end
      last_byte = item.char_byte;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    rld_pkg::out_item_t want;
    if (!rst_ni) begin
      clear_stream();
      owed_results.delete();
      mismatches_o   = 0;
      results_seen_o = 0;
      ends_ok_o      = 0;
      ends_empty_o   = 0;
      ends_leading_o = 0;
      ends_trunc_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_item(in_item_i);
      end
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (owed_results.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected result byte %02h status %0d last %0b",
                   $time, out_item_i.out_byte, out_item_i.status, out_item_i.run_last);
        end else begin
          want = owed_results.pop_front();
          if (out_item_i.out_byte !== want.out_byte || out_item_i.status !== want.status ||
              out_item_i.run_last !== want.run_last) begin
            mismatches_o++;
            $display("%0t: mismatch, expected %02h/%0d/%0b, got %02h/%0d/%0b",
                     $time, want.out_byte, want.status, want.run_last,
                     out_item_i.out_byte, out_item_i.status, out_item_i.run_last);
          end
        end
      end
    end
    backlog_o = owed_results.size();
  end

endmodule

### tb/tb_run_length_digit_decoder_top.sv
// testbench top: drives encoded streams into the decoder and gives the verdict
module tb_run_length_digit_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod   = 2;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomItems  = 110;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned DrainCycles  = 16;
  localparam logic        DataItem     = 1'b0;
  localparam logic        EndItem      = 1'b1;

  // nine-runs needed to come just short of the output limit
  localparam int unsigned FullRuns     = (rld_pkg::MaxOut - 1) / 9;
  localparam int unsigned ShortFall    = rld_pkg::MaxOut - 9 * FullRuns;
  localparam logic [7:0]  ExactDigit   = 8'(rld_pkg::DigitLo + ShortFall);
  localparam logic [7:0]  OverDigit    = 8'(rld_pkg::DigitLo + ShortFall + 1);

  typedef enum logic [1:0] {
    RdyAlways,
    RdyCoin,
    RdyEveryFourth,
    RdyScarce
  } ready_mode_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  rld_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rld_pkg::out_item_t out_item;

  int unsigned mismatches;
  int unsigned backlog;
  int unsigned results_seen;
  int unsigned ends_ok;
  int unsigned ends_empty;
  int unsigned ends_leading;
  int unsigned ends_trunc;

  int unsigned burst_left    = 0;
  int unsigned items_sent    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned cycles_run    = 0;

  always #(HalfPeriod) clk = ~clk;

  run_length_digit_decoder_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  run_length_digit_decoder_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .mismatches_o  (mismatches),
    .backlog_o     (backlog),
    .results_seen_o(results_seen),
    .ends_ok_o     (ends_ok),
    .ends_empty_o  (ends_empty),
    .ends_leading_o(ends_leading),
    .ends_trunc_o  (ends_trunc)
  );

  function automatic logic [7:0] pick_plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b >= rld_pkg::DigitLo && b <= rld_pkg::DigitHi);
    return b;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(rld_pkg::DigitLo + $urandom_range(0, 9));
  endfunction

  // one transfer on the input channel, with bursts and random gaps between them
  task automatic offer(input logic [7:0] b, input logic end_f);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: gap = 0;
        7:          gap = $urandom_range(8, 30);
        default:    gap = $urandom_range(1, 4);
      endcase
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_item  = '{char_byte: b, end_flag: end_f};
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // stop offering until every owed result has come out
  task automatic await_drain();
    in_valid = 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  // a stream of nine-runs that crosses the output limit; the closing digit picks
  // whether the limit lands on a run boundary or cuts a run short
  task automatic offer_long_stream(input logic [7:0] closing_digit);
    offer(pick_plain_byte(), DataItem);
    repeat (FullRuns) offer(rld_pkg::DigitHi, DataItem);
    offer(closing_digit, DataItem);
    repeat (4) offer($urandom_range(0, 1) ? pick_digit() : pick_plain_byte(), DataItem);
    offer(8'($urandom_range(0, 255)), EndItem);
  endtask

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin : receiver
    ready_mode_e mode;
    int unsigned mode_left;
    int unsigned phase;
    mode      = RdyAlways;
    mode_left = 0;
    phase     = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        out_ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        phase++;
        case (mode)
          RdyAlways:      out_ready = 1'b1;
          RdyCoin:        out_ready = 1'($urandom_range(0, 1));
          RdyEveryFourth: out_ready = (phase % 4) != 0;
          default:        out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    while (cycles_run < CycleLimit) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("run_length_digit_decoder_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned rand_items;
    int unsigned stream_no;
    int unsigned len;
    logic [7:0]  b;
    rand_items = 0;
    stream_no  = 0;
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // end item alone gives an empty stream
    offer(8'h00, EndItem);
    // leading digit silences the whole stream
    offer(rld_pkg::DigitLo + 8'd5, DataItem);
    offer("x", DataItem);
    offer(rld_pkg::DigitLo + 8'd3, DataItem);
    offer(8'hff, EndItem);
    // byte extremes, digit zero, and a digit repeated as data
    offer(8'h00, DataItem);
    offer(rld_pkg::DigitHi, DataItem);
    offer(8'hff, DataItem);
    offer(rld_pkg::DigitLo + 8'd1, DataItem);
    offer(rld_pkg::DigitLo, DataItem);
    offer(rld_pkg::DigitHi, DataItem);
    offer("A", DataItem);
    offer(rld_pkg::DigitLo + 8'd2, DataItem);
    offer(8'ha5, EndItem);
    // bytes just outside the digit range are plain data
    offer(rld_pkg::DigitLo - 8'd1, DataItem);
    offer(rld_pkg::DigitHi + 8'd1, DataItem);
    offer(rld_pkg::DigitLo + 8'd4, DataItem);
    offer(rld_pkg::DigitLo - 8'd1, DataItem);
    offer(8'h5a, EndItem);
    // single plain byte, nothing emitted
    offer("q", DataItem);
    offer(8'h00, EndItem);

    // output limit hit exactly at a run end, then hit in the middle of a run
    offer_long_stream(ExactDigit);
    offer_long_stream(OverDigit);

    // random streams, mostly well formed, some empty or with a leading digit
    while (rand_items < RandomItems) begin
      if (stream_no == 2) begin
        hold_requests++;
      end
      if (stream_no == 7) begin
        await_drain();
      end
      len = $urandom_range(0, 12);
      for (int unsigned k = 0; k < len; k++) begin
        if (k == 0) begin
          b = ($urandom_range(0, 7) == 0) ? pick_digit() : pick_plain_byte();
        end else if ($urandom_range(0, 9) < 6) begin
          b = pick_digit();
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        offer(b, DataItem);
        rand_items++;
      end
      offer(8'($urandom_range(0, 255)), EndItem);
      rand_items++;
      stream_no++;
    end

    await_drain();
    repeat (DrainCycles) @(negedge clk);
    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("stream endings: ok %0d, empty %0d, leading digit %0d, truncated %0d",
             ends_ok, ends_empty, ends_leading, ends_trunc);
    if (mismatches == 0 && backlog == 0) begin
      $display("run_length_digit_decoder_top regression: pass");
    end else begin
      $display("run_length_digit_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
